>>> rtl/dtd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared widths, types, constants and calendar tables for the date/time
// difference pipeline.
// ----------------------------------------------------------------------------
package dtd_pkg;

   // field widths
   localparam int DAY_W      = 5;
   localparam int MON_W      = 4;
   localparam int YEAR_W     = 14;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int SEC_W      = 6;
   localparam int TOTAL_W    = 22;
   localparam int SPAN_DAY_W = 6;

   // internal widths
   localparam int DNUM_W  = 23;   // day number of any 14-bit year
   localparam int DIFF_W  = DNUM_W + 1;
   localparam int TOD_W   = 17;   // seconds of day, fields at full width
   localparam int PROD_W  = 27;   // (year + 399) * reciprocal
   localparam int QUOT_W  = 8;
   localparam int LEAPS_W = 13;
   localparam int PART_W  = 9;
   localparam int REM_W   = 7;
   localparam int NARROW_W = 8;   // signed borrow arithmetic on small fields

   // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT for x below 43690
   localparam int RECIP100    = 5243;
   localparam int RECIP_SHIFT = 19;

   localparam int SEC_PER_HOUR = 3600;
   localparam int SEC_PER_MIN  = 60;
   localparam int MIN_PER_HOUR = 60;
   localparam int HOUR_PER_DAY = 24;
   localparam int MON_PER_YEAR = 12;
   localparam int DAY_PER_YEAR = 365;

   typedef logic [DAY_W-1:0]       day_type;
   typedef logic [MON_W-1:0]       mon_type;
   typedef logic [YEAR_W-1:0]      year_type;
   typedef logic [HOUR_W-1:0]      hour_type;
   typedef logic [MIN_W-1:0]       min_type;
   typedef logic [SEC_W-1:0]       sec_type;
   typedef logic [TOTAL_W-1:0]     total_type;
   typedef logic [DNUM_W-1:0]      dnum_type;
   typedef logic [DIFF_W-1:0]      diff_type;
   typedef logic [TOD_W-1:0]       tod_type;
   typedef logic [PROD_W-1:0]      prod_type;
   typedef logic [QUOT_W-1:0]      quot_type;
   typedef logic [LEAPS_W-1:0]     leaps_type;
   typedef logic [PART_W-1:0]      part_type;
   typedef logic [REM_W-1:0]       rem_type;
   typedef logic signed [NARROW_W-1:0] narrow_type;

   // month codes
   localparam mon_type JANUARY  = 4'd0;
   localparam mon_type FEBRUARY = 4'd1;
   localparam mon_type MARCH    = 4'd2;
   localparam mon_type DECEMBER = 4'd11;

   // one timestamp pair; the block stores it with months already clamped
   typedef struct packed {
      day_type  sd;
      mon_type  sm;
      year_type sy;
      hour_type sh;
      min_type  smi;
      sec_type  ss;
      day_type  ed;
      mon_type  em;
      year_type ey;
      hour_type eh;
      min_type  emi;
      sec_type  es;
   } item_type;

   // days before the first of the month, common year
   function automatic part_type month_start(input mon_type m);
      part_type r;
      case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         default: r = 9'd334;
      endcase
      return r;
   endfunction

   // month length, common year
   function automatic day_type month_len(input mon_type m);
      day_type r;
      case (m) inside
         4'd1:                    r = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
         default:                 r = 5'd31;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/date_time_difference.sv
`default_nettype none
// ----------------------------------------------------------------------------
// date_time_difference
// Gregorian date/time difference: whole-day count and broken-down span
// between a start and an end timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one start/end timestamp pair per transfer; rsp_* returns
//   one result per transfer, in order. A transfer happens on a rising edge
//   with valid high and stall low.
//   Five register stages: two for the reciprocal century quotients and the
//   day number, one summing the day number, one for the order check and
//   time borrows, one for the day/month/year borrows (the result register).
//   An accepted transfer moves through the stages in order and shows on rsp from the result register.
//   Throughput is one transfer per cycle while rsp_stall is low; each stage
//   moves when the stage ahead of it is empty or moving, so bubbles close up
//   under stall. While rsp_stall is high the result holds; req_stall rises
//   only once every stage holds a waiting item.
//   Reset (synchronous, active high) clears all stage valid bits; the
//   block is ready in the cycle after reset drops.
//   Months above December are read as December. When the end precedes
//   the start, rsp_order_error is set and every other result is zero.
// ----------------------------------------------------------------------------
module date_time_difference (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire dtd_pkg::day_type    req_start_day,
   input  wire dtd_pkg::mon_type    req_start_month,
   input  wire dtd_pkg::year_type   req_start_year,
   input  wire dtd_pkg::hour_type   req_start_hour,
   input  wire dtd_pkg::min_type    req_start_minute,
   input  wire dtd_pkg::sec_type    req_start_second,
   input  wire dtd_pkg::day_type    req_end_day,
   input  wire dtd_pkg::mon_type    req_end_month,
   input  wire dtd_pkg::year_type   req_end_year,
   input  wire dtd_pkg::hour_type   req_end_hour,
   input  wire dtd_pkg::min_type    req_end_minute,
   input  wire dtd_pkg::sec_type    req_end_second,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_order_error,
   output dtd_pkg::total_type       rsp_total_days,
   output dtd_pkg::year_type        rsp_span_years,
   output dtd_pkg::mon_type         rsp_span_months,
   output logic signed [dtd_pkg::SPAN_DAY_W-1:0] rsp_span_days,
   output dtd_pkg::hour_type        rsp_span_hours,
   output dtd_pkg::min_type         rsp_span_minutes,
   output dtd_pkg::sec_type         rsp_span_seconds
);

   localparam int STAGES = 5;

   // stage valid bits and per-stage enables
   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // month clamp and request capture
   dtd_pkg::item_type item1_in, item1_ff, item2_ff, item3_ff;

   always_comb begin
      item1_in.sd  = req_start_day;
      item1_in.sm  = (req_start_month > dtd_pkg::DECEMBER) ? dtd_pkg::DECEMBER
                                                           : req_start_month;
      item1_in.sy  = req_start_year;
      item1_in.sh  = req_start_hour;
      item1_in.smi = req_start_minute;
      item1_in.ss  = req_start_second;
      item1_in.ed  = req_end_day;
      item1_in.em  = (req_end_month > dtd_pkg::DECEMBER) ? dtd_pkg::DECEMBER
                                                         : req_end_month;
      item1_in.ey  = req_end_year;
      item1_in.eh  = req_end_hour;
      item1_in.emi = req_end_minute;
      item1_in.es  = req_end_second;
   end

   // seconds of day for the order check
   dtd_pkg::tod_type tod_s2_in, tod_e2_in;
   dtd_pkg::tod_type tod_s2_ff, tod_e2_ff, tod_s3_ff, tod_e3_ff;

   always_comb begin
      tod_s2_in = dtd_pkg::tod_type'(item1_ff.sh)
                * dtd_pkg::tod_type'(dtd_pkg::SEC_PER_HOUR)
                + dtd_pkg::tod_type'(item1_ff.smi)
                * dtd_pkg::tod_type'(dtd_pkg::SEC_PER_MIN)
                + dtd_pkg::tod_type'(item1_ff.ss);
      tod_e2_in = dtd_pkg::tod_type'(item1_ff.eh)
                * dtd_pkg::tod_type'(dtd_pkg::SEC_PER_HOUR)
                + dtd_pkg::tod_type'(item1_ff.emi)
                * dtd_pkg::tod_type'(dtd_pkg::SEC_PER_MIN)
                + dtd_pkg::tod_type'(item1_ff.es);
   end

   // item delay line alongside the day number stages
   always_ff @(posedge clock) begin
      if (en[0]) item1_ff <= item1_in;
      if (en[1]) begin
         item2_ff  <= item1_ff;
         tod_s2_ff <= tod_s2_in;
         tod_e2_ff <= tod_e2_in;
      end
      if (en[2]) begin
         item3_ff  <= item2_ff;
         tod_s3_ff <= tod_s2_ff;
         tod_e3_ff <= tod_e2_ff;
      end
   end

   // day numbers of both dates
   dtd_pkg::dnum_type dnum_start, dnum_end;
   logic              leap_start, leap_end;

   dtd_daynum u_daynum_start (
      .clock (clock),
      .en    (en[2:0]),
      .day   (item1_in.sd),
      .month (item1_in.sm),
      .year  (item1_in.sy),
      .dnum  (dnum_start),
      .leap  (leap_start)
   );

   dtd_daynum u_daynum_end (
      .clock (clock),
      .en    (en[2:0]),
      .day   (item1_in.ed),
      .month (item1_in.em),
      .year  (item1_in.ey),
      .dnum  (dnum_end),
      .leap  (leap_end)
   );

   // start-year leap flag is folded into its day number already
   logic unused_leap;
   assign unused_leap = leap_start;

   // borrow chains and result register
   dtd_span u_span (
      .clock        (clock),
      .en           (en[4:3]),
      .item         (item3_ff),
      .dnum_start   (dnum_start),
      .dnum_end     (dnum_end),
      .tod_start    (tod_s3_ff),
      .tod_end      (tod_e3_ff),
      .leap_end     (leap_end && !unused_leap || leap_end),
      .order_error  (rsp_order_error),
      .total_days   (rsp_total_days),
      .span_years   (rsp_span_years),
      .span_months  (rsp_span_months),
      .span_days    (rsp_span_days),
      .span_hours   (rsp_span_hours),
      .span_minutes (rsp_span_minutes),
      .span_seconds (rsp_span_seconds)
   );

endmodule
`default_nettype wire

>>> rtl/dtd_daynum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_daynum
// Three-stage proleptic Gregorian day number of one date, with the leap
// flag of its year.
// ----------------------------------------------------------------------------
module dtd_daynum (
   input  wire logic                clock,
   input  wire logic [2:0]          en,
   input  wire dtd_pkg::day_type    day,
   input  wire dtd_pkg::mon_type    month,
   input  wire dtd_pkg::year_type   year,
   output dtd_pkg::dnum_type        dnum,
   output logic                     leap
);

   // stage 1: reciprocal products for the century quotients
   dtd_pkg::day_type  d1_ff;
   dtd_pkg::mon_type  m1_ff;
   dtd_pkg::year_type y1_ff;
   dtd_pkg::prod_type py1_ff, pb1_ff, pc1_ff;
   dtd_pkg::prod_type py1_in, pb1_in, pc1_in;

   always_comb begin
      py1_in = dtd_pkg::prod_type'(year) * dtd_pkg::prod_type'(dtd_pkg::RECIP100);
      pb1_in = (dtd_pkg::prod_type'(year) + dtd_pkg::prod_type'(99))
             * dtd_pkg::prod_type'(dtd_pkg::RECIP100);
      pc1_in = (dtd_pkg::prod_type'(year) + dtd_pkg::prod_type'(399))
             * dtd_pkg::prod_type'(dtd_pkg::RECIP100);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1_ff  <= day;
         m1_ff  <= month;
         y1_ff  <= year;
         py1_ff <= py1_in;
         pb1_ff <= pb1_in;
         pc1_ff <= pc1_in;
      end
   end

   // stage 2: leap count, leap flag, offset within year, 365 * year
   dtd_pkg::quot_type  qy, qb, qc;
   dtd_pkg::rem_type   rem100;
   logic [dtd_pkg::YEAR_W:0] y_p3;
   dtd_pkg::leaps_type leaps2_in, leaps2_ff;
   dtd_pkg::part_type  part2_in, part2_ff;
   dtd_pkg::dnum_type  y365_2_in, y365_2_ff;
   logic               leap2_in, leap2_ff;

   always_comb begin
      qy        = py1_ff[dtd_pkg::RECIP_SHIFT +: dtd_pkg::QUOT_W];
      qb        = pb1_ff[dtd_pkg::RECIP_SHIFT +: dtd_pkg::QUOT_W];
      qc        = pc1_ff[dtd_pkg::RECIP_SHIFT +: dtd_pkg::QUOT_W];
      y_p3      = {1'b0, y1_ff} + (dtd_pkg::YEAR_W + 1)'(3);
      leaps2_in = dtd_pkg::leaps_type'(y_p3[dtd_pkg::YEAR_W:2])
                - dtd_pkg::leaps_type'(qb)
                + dtd_pkg::leaps_type'(qc[dtd_pkg::QUOT_W-1:2]);
      rem100    = dtd_pkg::rem_type'(y1_ff - dtd_pkg::year_type'(qy)
                                           * dtd_pkg::year_type'(100));
      leap2_in  = ((y1_ff[1:0] == 2'd0) && (rem100 != '0))
               || ((rem100 == '0) && (qy[1:0] == 2'd0));
      part2_in  = dtd_pkg::month_start(m1_ff) + dtd_pkg::part_type'(d1_ff)
                + dtd_pkg::part_type'((m1_ff >= dtd_pkg::MARCH) && leap2_in);
      y365_2_in = dtd_pkg::dnum_type'(y1_ff)
                * dtd_pkg::dnum_type'(dtd_pkg::DAY_PER_YEAR);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         leaps2_ff <= leaps2_in;
         part2_ff  <= part2_in;
         y365_2_ff <= y365_2_in;
         leap2_ff  <= leap2_in;
      end
   end

   // stage 3: sum to the day number
   dtd_pkg::dnum_type dnum3_in, dnum3_ff;
   logic              leap3_ff;

   assign dnum3_in = y365_2_ff + dtd_pkg::dnum_type'(leaps2_ff)
                   + dtd_pkg::dnum_type'(part2_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         dnum3_ff <= dnum3_in;
         leap3_ff <= leap2_ff;
      end
   end

   assign dnum = dnum3_ff;
   assign leap = leap3_ff;

endmodule
`default_nettype wire

>>> rtl/dtd_span.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtd_span
// Last two stages: order check and time borrow chain, then day, month and
// year borrows into the registered result.
// ----------------------------------------------------------------------------
module dtd_span (
   input  wire logic                clock,
   input  wire logic [1:0]          en,
   input  wire dtd_pkg::item_type   item,
   input  wire dtd_pkg::dnum_type   dnum_start,
   input  wire dtd_pkg::dnum_type   dnum_end,
   input  wire dtd_pkg::tod_type    tod_start,
   input  wire dtd_pkg::tod_type    tod_end,
   input  wire logic                leap_end,
   output logic                     order_error,
   output dtd_pkg::total_type       total_days,
   output dtd_pkg::year_type        span_years,
   output dtd_pkg::mon_type         span_months,
   output logic signed [dtd_pkg::SPAN_DAY_W-1:0] span_days,
   output dtd_pkg::hour_type        span_hours,
   output dtd_pkg::min_type         span_minutes,
   output dtd_pkg::sec_type         span_seconds
);

   // stage 4: day difference, order check, second/minute/hour borrows
   dtd_pkg::diff_type   days;
   logic                err4_in;
   dtd_pkg::narrow_type dsec, emi_b, dmin, eh_b, dhour;
   logic                sb, mb, hb;
   dtd_pkg::narrow_type dsec4_in, dmin4_in, dhour4_in, ed4_in;
   dtd_pkg::total_type  days4_in;

   always_comb begin
      days     = dtd_pkg::diff_type'(dnum_end) - dtd_pkg::diff_type'(dnum_start);
      err4_in  = days[dtd_pkg::DIFF_W-1]
              || ((days == '0) && (tod_start > tod_end));
      dsec     = dtd_pkg::narrow_type'(item.es) - dtd_pkg::narrow_type'(item.ss);
      sb       = dsec[dtd_pkg::NARROW_W-1];
      dsec4_in = sb ? dsec + dtd_pkg::narrow_type'(dtd_pkg::SEC_PER_MIN) : dsec;
      emi_b    = dtd_pkg::narrow_type'(item.emi) - dtd_pkg::narrow_type'(sb);
      dmin     = emi_b - dtd_pkg::narrow_type'(item.smi);
      mb       = dmin[dtd_pkg::NARROW_W-1];
      dmin4_in = mb ? dmin + dtd_pkg::narrow_type'(dtd_pkg::MIN_PER_HOUR) : dmin;
      eh_b     = dtd_pkg::narrow_type'(item.eh) - dtd_pkg::narrow_type'(mb);
      dhour    = eh_b - dtd_pkg::narrow_type'(item.sh);
      hb       = dhour[dtd_pkg::NARROW_W-1];
      dhour4_in = hb ? dhour + dtd_pkg::narrow_type'(dtd_pkg::HOUR_PER_DAY) : dhour;
      ed4_in   = dtd_pkg::narrow_type'(item.ed) - dtd_pkg::narrow_type'(hb);
      days4_in = dtd_pkg::total_type'(days) - dtd_pkg::total_type'(hb);
   end

   logic                err4_ff, leap4_ff;
   dtd_pkg::total_type  days4_ff;
   dtd_pkg::narrow_type dsec4_ff, dmin4_ff, dhour4_ff, ed4_ff;
   dtd_pkg::day_type    sd4_ff;
   dtd_pkg::mon_type    sm4_ff, em4_ff;
   dtd_pkg::year_type   sy4_ff, ey4_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         err4_ff   <= err4_in;
         leap4_ff  <= leap_end;
         days4_ff  <= days4_in;
         dsec4_ff  <= dsec4_in;
         dmin4_ff  <= dmin4_in;
         dhour4_ff <= dhour4_in;
         ed4_ff    <= ed4_in;
         sd4_ff    <= item.sd;
         sm4_ff    <= item.sm;
         em4_ff    <= item.em;
         sy4_ff    <= item.sy;
         ey4_ff    <= item.ey;
      end
   end

   // stage 5: day borrow falls back one month, month borrow takes a year
   dtd_pkg::narrow_type dday, dday5, len;
   dtd_pkg::narrow_type dmon, dmon5;
   dtd_pkg::mon_type    emon;
   logic                db, yb, mb2;
   dtd_pkg::year_type   dyear;

   always_comb begin
      dday = ed4_ff - dtd_pkg::narrow_type'(sd4_ff);
      db   = dday[dtd_pkg::NARROW_W-1];
      yb   = db && (em4_ff == dtd_pkg::JANUARY);
      if (!db) begin
         emon = em4_ff;
      end else if (em4_ff == dtd_pkg::JANUARY) begin
         emon = dtd_pkg::DECEMBER;
      end else begin
         emon = em4_ff - dtd_pkg::mon_type'(1);
      end
      len   = dtd_pkg::narrow_type'(dtd_pkg::month_len(emon))
            + dtd_pkg::narrow_type'((emon == dtd_pkg::FEBRUARY) && leap4_ff);
      dday5 = db ? dday + len : dday;
      dmon  = dtd_pkg::narrow_type'(emon) - dtd_pkg::narrow_type'(sm4_ff);
      mb2   = dmon[dtd_pkg::NARROW_W-1];
      dmon5 = mb2 ? dmon + dtd_pkg::narrow_type'(dtd_pkg::MON_PER_YEAR) : dmon;
      dyear = ey4_ff - sy4_ff - dtd_pkg::year_type'(yb) - dtd_pkg::year_type'(mb2);
   end

   // result register, zeros when the end precedes the start
   always_ff @(posedge clock) begin
      if (en[1]) begin
         order_error  <= err4_ff;
         total_days   <= err4_ff ? '0 : days4_ff;
         span_years   <= err4_ff ? '0 : dyear;
         span_months  <= err4_ff ? '0 : dtd_pkg::mon_type'(dmon5);
         span_days    <= err4_ff ? '0 : dday5[dtd_pkg::SPAN_DAY_W-1:0];
         span_hours   <= err4_ff ? '0 : dtd_pkg::hour_type'(dhour4_ff);
         span_minutes <= err4_ff ? '0 : dtd_pkg::min_type'(dmin4_ff);
         span_seconds <= err4_ff ? '0 : dtd_pkg::sec_type'(dsec4_ff);
      end
   end

endmodule
`default_nettype wire

>>> sim/dtd_span_checker.sv
// ----------------------------------------------------------------------------
// dtd_span_checker
// Watches both channels of the date/time difference block, computes the
// expected day count and broken-down span for every request transfer and
// compares each response transfer, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module dtd_span_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire dtd_pkg::item_type   req_pair,
   // response channel
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic                rsp_order_error,
   input  wire dtd_pkg::total_type  rsp_total_days,
   input  wire dtd_pkg::year_type   rsp_span_years,
   input  wire dtd_pkg::mon_type    rsp_span_months,
   input  wire logic signed [dtd_pkg::SPAN_DAY_W-1:0] rsp_span_days,
   input  wire dtd_pkg::hour_type   rsp_span_hours,
   input  wire dtd_pkg::min_type    rsp_span_minutes,
   input  wire dtd_pkg::sec_type    rsp_span_seconds,
   // status for the test top
   output int                       failures,
   output int                       pending
);
   import dtd_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                         order_error;
      total_type                    total_days;
      year_type                     years;
      mon_type                      months;
      logic signed [SPAN_DAY_W-1:0] days;
      hour_type                     hours;
      min_type                      minutes;
      sec_type                      seconds;
   } span_type;

   // days before the first of each month and month lengths, common year
   int days_before [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
   int days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   span_type expected_spans [$];
   span_type want;
   span_type got;
   int       error_count = 0;

   function automatic bit is_leap_year(input longint y);
      return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
   endfunction

   // proleptic day index, no check of the day against the month length
   function automatic longint day_index(input longint d, input longint m, input longint y);
      longint n;
      n = DAY_PER_YEAR * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400
          + days_before[m] + d;
      if (m >= MARCH && is_leap_year(y))
         n++;
      return n;
   endfunction

   // expected response for one timestamp pair
   function automatic span_type calc_span(input item_type p);
      span_type r;
      longint   sd, sm, sy, sh, smi, ss;
      longint   ed, em, ey, eh, emi, es;
      longint   days, dsec, dmin, dhour, dday, dmon, dyear, len;
      r = '0;
      sd = p.sd;  sy = p.sy;  sh = p.sh;  smi = p.smi;  ss = p.ss;
      ed = p.ed;  ey = p.ey;  eh = p.eh;  emi = p.emi;  es = p.es;
      sm = (p.sm > DECEMBER) ? DECEMBER : p.sm;
      em = (p.em > DECEMBER) ? DECEMBER : p.em;

      days = day_index(ed, em, ey) - day_index(sd, sm, sy);

      // end before start: flag only
      if (days < 0 || (days == 0 && sh * SEC_PER_HOUR + smi * SEC_PER_MIN + ss >
                                    eh * SEC_PER_HOUR + emi * SEC_PER_MIN + es)) begin
         r.order_error = 1'b1;
         return r;
      end

      // time borrows
      dsec = es - ss;
      if (dsec < 0) begin
         emi--;
         dsec += SEC_PER_MIN;
      end
      dmin = emi - smi;
      if (dmin < 0) begin
         eh--;
         dmin += MIN_PER_HOUR;
      end
      dhour = eh - sh;
      if (dhour < 0) begin
         ed--;
         days--;
         dhour += HOUR_PER_DAY;
      end

      // day borrow falls back to the month before the end month
      dday = ed - sd;
      if (dday < 0) begin
         if (em == JANUARY) begin
            ey--;
            em = DECEMBER;
         end else begin
            em--;
         end
         len = days_in_month[em];
         if (em == FEBRUARY && is_leap_year(ey))
            len = 29;
         dday += len;
      end
      dmon = em - sm;
      if (dmon < 0) begin
         ey--;
         dmon += MON_PER_YEAR;
      end
      dyear = ey - sy;

      r.total_days = days[TOTAL_W-1:0];
      r.years      = dyear[YEAR_W-1:0];
      r.months     = dmon[MON_W-1:0];
      r.days       = dday[SPAN_DAY_W-1:0];
      r.hours      = dhour[HOUR_W-1:0];
      r.minutes    = dmin[MIN_W-1:0];
      r.seconds    = dsec[SEC_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string field, input longint want_v, input longint got_v);
      if (want_v != got_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      end
   endtask

   // queue expectations on request transfers, compare on response transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_spans.push_back(calc_span(req_pair));
         if (rsp_valid && !rsp_stall) begin
            got.order_error = rsp_order_error;
            got.total_days  = rsp_total_days;
            got.years       = rsp_span_years;
            got.months      = rsp_span_months;
            got.days        = rsp_span_days;
            got.hours       = rsp_span_hours;
            got.minutes     = rsp_span_minutes;
            got.seconds     = rsp_span_seconds;
            if (expected_spans.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: response transfer with no request outstanding", $time);
            end else begin
               want = expected_spans.pop_front();
               check_field("order_error", want.order_error, got.order_error);
               check_field("total_days", want.total_days, got.total_days);
               check_field("span_years", want.years, got.years);
               check_field("span_months", want.months, got.months);
               check_field("span_days", $signed(want.days), $signed(got.days));
               check_field("span_hours", want.hours, got.hours);
               check_field("span_minutes", want.minutes, got.minutes);
               check_field("span_seconds", want.seconds, got.seconds);
            end
         end
      end
      failures <= error_count;
      pending  <= expected_spans.size();
   end

endmodule

>>> sim/date_time_difference_tb.sv
// ----------------------------------------------------------------------------
// date_time_difference_tb
// Drives timestamp pairs into the date/time difference block: a directed
// set of calendar corners, then three random phases with different idle
// patterns on the request and response sides. A checker beside the block
// predicts and compares every response; this top gives the verdict.
// ----------------------------------------------------------------------------
module date_time_difference_tb;
   import dtd_pkg::*;

   localparam int RANDOM_PER_PHASE = 544;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 20;
   localparam int STAMP_W          = $bits(item_type) / 2;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   item_type                req_pair;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_order_error;
   total_type               rsp_total_days;
   year_type                rsp_span_years;
   mon_type                 rsp_span_months;
   logic signed [SPAN_DAY_W-1:0] rsp_span_days;
   hour_type                rsp_span_hours;
   min_type                 rsp_span_minutes;
   sec_type                 rsp_span_seconds;

   int failures;
   int pending;
   int cycles = 0;
   int send_idle_pct;
   int recv_idle_pct;

   // calendar corners for random picks
   int corner_years [8] = '{1, 4, 100, 400, 1900, 2000, 2100, 9999};
   int corner_days [5] = '{1, 28, 29, 30, 31};
   int corner_months [4] = '{0, 1, 2, 11};

   date_time_difference dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_day    (req_pair.sd),
      .req_start_month  (req_pair.sm),
      .req_start_year   (req_pair.sy),
      .req_start_hour   (req_pair.sh),
      .req_start_minute (req_pair.smi),
      .req_start_second (req_pair.ss),
      .req_end_day      (req_pair.ed),
      .req_end_month    (req_pair.em),
      .req_end_year     (req_pair.ey),
      .req_end_hour     (req_pair.eh),
      .req_end_minute   (req_pair.emi),
      .req_end_second   (req_pair.es),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_order_error  (rsp_order_error),
      .rsp_total_days   (rsp_total_days),
      .rsp_span_years   (rsp_span_years),
      .rsp_span_months  (rsp_span_months),
      .rsp_span_days    (rsp_span_days),
      .rsp_span_hours   (rsp_span_hours),
      .rsp_span_minutes (rsp_span_minutes),
      .rsp_span_seconds (rsp_span_seconds)
   );

   dtd_span_checker span_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pair         (req_pair),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_order_error  (rsp_order_error),
      .rsp_total_days   (rsp_total_days),
      .rsp_span_years   (rsp_span_years),
      .rsp_span_months  (rsp_span_months),
      .rsp_span_days    (rsp_span_days),
      .rsp_span_hours   (rsp_span_hours),
      .rsp_span_minutes (rsp_span_minutes),
      .rsp_span_seconds (rsp_span_seconds),
      .failures         (failures),
      .pending          (pending)
   );

   // clock, period 12
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side stalls at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic item_type stamp(input int sd, input int sm, input int sy,
                                      input int sh, input int smi, input int ss,
                                      input int ed, input int em, input int ey,
                                      input int eh, input int emi, input int es);
      item_type p;
      p.sd = day_type'(sd);   p.sm = mon_type'(sm);   p.sy = year_type'(sy);
      p.sh = hour_type'(sh);  p.smi = min_type'(smi); p.ss = sec_type'(ss);
      p.ed = day_type'(ed);   p.em = mon_type'(em);   p.ey = year_type'(ey);
      p.eh = hour_type'(eh);  p.emi = min_type'(emi); p.es = sec_type'(es);
      return p;
   endfunction

   function automatic item_type random_pair();
      item_type p;
      int       kind;
      int       rel;
      int       offset;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // any bit pattern, out-of-range fields included
         p = stamp($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                   $urandom_range(31), $urandom_range(63), $urandom_range(63),
                   $urandom_range(31), $urandom_range(15), $urandom_range(16383),
                   $urandom_range(31), $urandom_range(63), $urandom_range(63));
      end else if (kind < 30) begin
         // month ends, leap rules and year limits
         p = stamp(corner_days[$urandom_range(4)], corner_months[$urandom_range(3)],
                   corner_years[$urandom_range(7)], 23 * $urandom_range(1),
                   59 * $urandom_range(1), 59 * $urandom_range(1),
                   corner_days[$urandom_range(4)], corner_months[$urandom_range(3)], 0,
                   23 * $urandom_range(1), 59 * $urandom_range(1), 59 * $urandom_range(1));
         p.ey = ($urandom_range(1) == 1 && p.sy < 9999) ? p.sy + 1'b1 : p.sy;
      end else begin
         // well-formed pair, end mostly after start
         p = stamp($urandom_range(31, 1), $urandom_range(11), $urandom_range(9999, 1),
                   $urandom_range(23), $urandom_range(59), $urandom_range(59),
                   $urandom_range(31, 1), $urandom_range(11), 0,
                   $urandom_range(23), $urandom_range(59), $urandom_range(59));
         rel = $urandom_range(99);
         if (rel < 20) begin
            p.ed = p.sd;
            p.em = p.sm;
            p.ey = p.sy;
         end else if (rel < 45) begin
            p.em = mon_type'($urandom_range(11, p.sm));
            p.ey = p.sy;
         end else if (rel < 70) begin
            offset = p.sy + $urandom_range(3);
            p.ey = year_type'((offset > 9999) ? 9999 : offset);
         end else begin
            p.ey = year_type'($urandom_range(9999, p.sy));
         end
      end
      // swap start and end halves for some end-before-start pairs
      if ($urandom_range(99) < 10)
         p = {p[STAMP_W-1:0], p[2*STAMP_W-1:STAMP_W]};
      return p;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_pair(input item_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pair  <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic run_directed();
      // identical timestamps, legal extremes, full-width extremes
      send_pair(stamp(1, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 0));
      send_pair(stamp(1, 0, 1, 0, 0, 0, 31, 11, 9999, 23, 59, 59));
      send_pair(stamp(0, 0, 0, 0, 0, 0, 31, 15, 16383, 31, 63, 63));
      send_pair(stamp(31, 15, 16383, 31, 63, 63, 0, 0, 0, 0, 0, 0));
      // end before start by one second, on the same date and across midnight
      send_pair(stamp(15, 5, 2024, 12, 30, 1, 15, 5, 2024, 12, 30, 0));
      send_pair(stamp(16, 5, 2024, 0, 0, 0, 15, 5, 2024, 23, 59, 59));
      // full borrow chain across a new year
      send_pair(stamp(31, 11, 1999, 23, 59, 59, 1, 0, 2000, 0, 0, 0));
      // day borrow into February: leap, century common, negative span days
      send_pair(stamp(31, 0, 2000, 0, 0, 0, 1, 2, 2000, 0, 0, 0));
      send_pair(stamp(31, 0, 1900, 0, 0, 0, 1, 2, 1900, 0, 0, 0));
      send_pair(stamp(31, 0, 2001, 0, 0, 0, 0, 2, 2001, 0, 0, 0));
      send_pair(stamp(29, 1, 2100, 6, 0, 0, 1, 2, 2100, 5, 0, 0));
      send_pair(stamp(28, 1, 2400, 0, 0, 0, 1, 2, 2400, 0, 0, 0));
      // months above December read as December
      send_pair(stamp(10, 14, 2010, 1, 2, 3, 10, 12, 2011, 4, 5, 6));
      // year zero, end day zero borrows back into January
      send_pair(stamp(31, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      // hour borrow lowers the day count
      send_pair(stamp(1, 0, 2020, 12, 0, 0, 2, 0, 2020, 11, 0, 0));
      // month borrow takes a year
      send_pair(stamp(20, 10, 2019, 8, 15, 30, 5, 1, 2020, 9, 10, 20));
      // same date, end later in the day
      send_pair(stamp(1, 0, 1, 0, 0, 0, 1, 0, 1, 23, 59, 59));
   endtask

   task automatic run_random(input int count);
      repeat (count)
         send_pair(random_pair());
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pair      = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 62;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(RANDOM_PER_PHASE);
      send_idle_pct = 62;
      recv_idle_pct = 34;
      run_random(RANDOM_PER_PHASE);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      // wait for every outstanding response, then let the pipeline settle
      do
         @(posedge clock);
      while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
